// ===== hdl/ccu_pkg.sv =====
// ----------------------------------------------------------------------------
// ccu_pkg
// Shared types and constants of the combinatorial counting unit.
// ----------------------------------------------------------------------------
package ccu_pkg;

	localparam int OP_W    = 3;
	localparam int SIZE_W  = 16;
	localparam int VALUE_W = 64;
	localparam int ERR_W   = 2;

	// factor and step count width: n + k - 1 needs one bit more than a count
	localparam int JOB_W = SIZE_W + 1;

	localparam int COUNT_WIDTH_DEF  = 16;
	localparam int RESULT_WIDTH_DEF = 64;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [OP_W-1:0] OP_FACT = 3'd0;
	localparam logic [OP_W-1:0] OP_PERM = 3'd1;
	localparam logic [OP_W-1:0] OP_POW  = 3'd2;
	localparam logic [OP_W-1:0] OP_COMB = 3'd3;
	localparam logic [OP_W-1:0] OP_MSET = 3'd4;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_PICK  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
	localparam logic [ERR_W-1:0] ERR_OVF   = 2'd3;

	localparam logic [1:0] MODE_UP    = 2'd0;
	localparam logic [1:0] MODE_DOWN  = 2'd1;
	localparam logic [1:0] MODE_CONST = 2'd2;
	localparam logic [1:0] MODE_BINOM = 2'd3;

	typedef struct packed {
		logic             zero;
		logic [ERR_W-1:0] err;
		logic [1:0]       mode;
		logic [JOB_W-1:0] factor;
		logic [JOB_W-1:0] steps;
	} job_t;

endpackage

// ===== hdl/ccu_if.sv =====
// ----------------------------------------------------------------------------
// ccu_if
// Valid/ready channels of the combinatorial counting unit.
// ----------------------------------------------------------------------------
interface ccu_in_if import ccu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [SIZE_W-1:0] set_size;
	logic [SIZE_W-1:0] pick_count;

	modport source (output valid, operation, set_size, pick_count, input ready);
	modport sink (input valid, operation, set_size, pick_count, output ready);
endinterface

interface ccu_out_if import ccu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] count_value;
	logic [ERR_W-1:0]   error_code;

	modport source (output valid, count_value, error_code, input ready);
	modport sink (input valid, count_value, error_code, output ready);
endinterface

// ===== hdl/ccu_front.sv =====
// ----------------------------------------------------------------------------
// ccu_front
// Accepts items, checks arguments and turns each into a multiply job.
// ----------------------------------------------------------------------------
module ccu_front import ccu_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	ccu_in_if.sink     in_ch,
	input  logic       q_full,
	output logic       push,
	output job_t       job
);

	localparam logic [SIZE_W-1:0] CMASK = SIZE_W'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [JOB_W-1:0] n, k, nk, nmk, nm1;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	assign n   = JOB_W'(in_ch.set_size & CMASK);
	assign k   = JOB_W'(in_ch.pick_count & CMASK);
	assign nk  = n + k - JOB_W'(1);
	assign nmk = n - k;
	assign nm1 = n - JOB_W'(1);

	always_comb begin
		job.zero   = 1'b1;
		job.err    = ERR_OK;
		job.mode   = MODE_UP;
		job.factor = '0;
		job.steps  = '0;
		case (in_ch.operation)
			OP_FACT: begin
				job.zero   = 1'b0;
				job.mode   = MODE_UP;
				job.factor = JOB_W'(2);
				job.steps  = (n >= JOB_W'(2)) ? nm1 : '0;
			end
			OP_PERM: begin
				if (k > n) begin
					job.err = ERR_PICK;
				end else begin
					job.zero   = 1'b0;
					job.mode   = MODE_DOWN;
					job.factor = n;
					job.steps  = k;
				end
			end
			OP_POW: begin
				if (n == '0 && k != '0) begin
					job.err = ERR_EMPTY;
				end else begin
					job.zero   = 1'b0;
					job.mode   = MODE_CONST;
					job.factor = n;
					job.steps  = (n == JOB_W'(1)) ? '0 : k;
				end
			end
			OP_COMB: begin
				if (k > n) begin
					job.err = ERR_PICK;
				end else begin
					job.zero   = 1'b0;
					job.mode   = MODE_BINOM;
					job.factor = n;
					job.steps  = (k > nmk) ? nmk : k;
				end
			end
			OP_MSET: begin
				if (n == '0 && k != '0) begin
					job.err = ERR_EMPTY;
				end else if (n == '0) begin
					job.zero = 1'b0;
				end else begin
					job.zero   = 1'b0;
					job.mode   = MODE_BINOM;
					job.factor = nk;
					job.steps  = (k > nm1) ? nm1 : k;
				end
			end
			default: begin
				job.zero = 1'b1;
			end
		endcase
	end

endmodule

// ===== hdl/ccu_queue.sv =====
// ----------------------------------------------------------------------------
// ccu_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module ccu_queue import ccu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t pop_job
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign avail   = (cnt_q != '0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// ===== hdl/ccu_back.sv =====
// ----------------------------------------------------------------------------
// ccu_back
// Runs jobs: shift-add multiply, restoring exact divide, saturation check.
// ----------------------------------------------------------------------------
module ccu_back import ccu_pkg::*; #(
	parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic avail,
	input  job_t job,
	output logic pop,
	ccu_out_if.source out_ch
);

	localparam int RW  = RESULT_WIDTH;
	localparam int PW  = RW + JOB_W;
	localparam int BCW = $clog2(PW);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_CHK  = 2'd3;

	logic [1:0]         state_q;
	logic               ovalid_q;
	logic [VALUE_W-1:0] oval_q;
	logic [ERR_W-1:0]   oerr_q;
	logic [1:0]         mode_q;
	logic [JOB_W-1:0]   f_q, d_q, cnt_q, mplier_q, rem_q;
	logic [PW-1:0]      prod_q, mcand_q;
	logic [BCW-1:0]     bit_q;

	logic [JOB_W:0]   rem_sh, rem_sub;
	logic             ge;
	logic [JOB_W-1:0] f_nx;

	assign out_ch.valid       = ovalid_q;
	assign out_ch.count_value = oval_q;
	assign out_ch.error_code  = oerr_q;

	assign pop = (state_q == S_IDLE) && !ovalid_q && avail;

	assign rem_sh  = {rem_q, prod_q[PW-1]};
	assign rem_sub = rem_sh - {1'b0, d_q};
	assign ge      = (rem_sh >= {1'b0, d_q});

	always_comb begin
		case (mode_q)
			MODE_UP:    f_nx = f_q + JOB_W'(1);
			MODE_CONST: f_nx = f_q;
			default:    f_nx = f_q - JOB_W'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q   <= job.mode;
				f_q      <= job.factor;
				cnt_q    <= job.steps;
				d_q      <= JOB_W'(1);
				prod_q   <= '0;
				mcand_q  <= PW'(1);
				mplier_q <= job.factor;
			end
			S_MUL: begin
				if (mplier_q == '0) begin
					rem_q <= '0;
					bit_q <= BCW'(PW - 1);
				end else begin
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= {mcand_q[PW-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[JOB_W-1:1]};
				end
			end
			S_DIV: begin
				rem_q  <= ge ? rem_sub[JOB_W-1:0] : rem_sh[JOB_W-1:0];
				prod_q <= {prod_q[PW-2:0], ge};
				bit_q  <= bit_q - BCW'(1);
			end
			default: begin
				f_q      <= f_nx;
				d_q      <= d_q + JOB_W'(1);
				cnt_q    <= cnt_q - JOB_W'(1);
				mcand_q  <= PW'(prod_q[RW-1:0]);
				mplier_q <= f_nx;
				prod_q   <= '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			oval_q   <= '0;
			oerr_q   <= ERR_OK;
		end else begin
			if (ovalid_q && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (job.zero) begin
							ovalid_q <= 1'b1;
							oval_q   <= '0;
							oerr_q   <= job.err;
						end else if (job.steps == '0) begin
							ovalid_q <= 1'b1;
							oval_q   <= VALUE_W'(1);
							oerr_q   <= ERR_OK;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mplier_q == '0) begin
						state_q <= (mode_q == MODE_BINOM) ? S_DIV : S_CHK;
					end
				end
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_CHK;
					end
				end
				default: begin
					if (prod_q[PW-1:RW] != '0) begin
						ovalid_q <= 1'b1;
						oval_q   <= VALUE_W'({RW{1'b1}});
						oerr_q   <= ERR_OVF;
						state_q  <= S_IDLE;
					end else if (cnt_q == JOB_W'(1)) begin
						ovalid_q <= 1'b1;
						oval_q   <= VALUE_W'(prod_q[RW-1:0]);
						oerr_q   <= ERR_OK;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/combinatorial_counting_unit.sv =====
// ----------------------------------------------------------------------------
// combinatorial_counting_unit
// Factorial, permutations, power, binomial and multiset counts, saturating.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   operation, set_size, pick_count
// out_ch   out  count_value, error_code
//
// One item runs a chain of multiply steps; each step is a shift-add multiply
// over the factor bits, for binomial forms a restoring divide that yields
// RESULT_WIDTH+17 quotient bits, and a saturation check. Binomial chains
// end within about 35 steps, the others within about RESULT_WIDTH short
// steps. Reset empties the queue and the output register. A two-item queue
// lets the front accept while the back is busy or its result is stalled.
// ----------------------------------------------------------------------------
module combinatorial_counting_unit import ccu_pkg::*; #(
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
	parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ccu_in_if.sink     in_ch,
	ccu_out_if.source  out_ch
);

	logic q_full, push, pop, avail;
	job_t push_job, pop_job;

	ccu_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	ccu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.avail    (avail),
		.pop_job  (pop_job)
	);

	ccu_back #(.RESULT_WIDTH(RESULT_WIDTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.job    (pop_job),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

// ===== bench/tb_combinatorial_counting_unit.sv =====
// ----------------------------------------------------------------------------
// tb_combinatorial_counting_unit
// Self-checking bench: a directed table of edge cases, then random items,
// each checked field by field against a value in the table or an in-bench
// count predictor, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_combinatorial_counting_unit;
	import ccu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned CNT_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int              N_RANDOM  = 270;
	localparam int              CALM_TAIL = 40;
	localparam longint          CYC_LIMIT = 4000000;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [SIZE_W-1:0]  n;
		logic [SIZE_W-1:0]  k;
		bit                 typed;
		logic [VALUE_W-1:0] val;
		logic [ERR_W-1:0]   err;
	} stim_row_t;

	typedef struct {
		logic [VALUE_W-1:0] val;
		logic [ERR_W-1:0]   err;
	} count_res_t;

	logic clk;
	logic arst_n;
	ccu_in_if  in_ch();
	ccu_out_if out_ch();

	combinatorial_counting_unit uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	count_res_t pending_counts[$];
	int  mismatches;
	int  results_seen;
	int  items_sent;
	bit  idling_on;
	int  out_stall;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit mul_fits(input longint unsigned a, input longint unsigned b,
			inout longint unsigned r);
		if (a != 0 && b > CNT_MAX / a)
			return 1'b0;
		r = a * b;
		return 1'b1;
	endfunction

	function automatic longint unsigned gcd_of(input longint unsigned a,
			input longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic bit binom_fits(input longint unsigned n, input longint unsigned k,
			output longint unsigned r);
		longint unsigned ek, acc, g, d;
		ek = (k > n - k) ? n - k : k;
		acc = 1;
		r = 0;
		for (longint unsigned i = 0; i < ek; i++) begin
			g = gcd_of(acc, i + 1);
			d = (i + 1) / g;
			if (!mul_fits(acc / g, (n - i) / d, acc))
				return 1'b0;
		end
		r = acc;
		return 1'b1;
	endfunction

	function automatic count_res_t predict_count(input logic [OP_W-1:0] op,
			input logic [SIZE_W-1:0] n_in, input logic [SIZE_W-1:0] k_in);
		count_res_t res;
		longint unsigned n, k, v;
		bit ok;
		n = 64'(n_in);
		k = 64'(k_in);
		v = 0;
		ok = 1'b1;
		res.err = ERR_OK;
		case (op)
			OP_FACT: begin
				v = 1;
				for (longint unsigned i = 2; i <= n && ok; i++)
					ok = mul_fits(v, i, v);
			end
			OP_PERM: begin
				if (k > n) begin
					res.err = ERR_PICK;
				end else begin
					v = 1;
					for (longint unsigned i = 0; i < k && ok; i++)
						ok = mul_fits(v, n - i, v);
				end
			end
			OP_POW: begin
				if (n == 0 && k > 0) begin
					res.err = ERR_EMPTY;
				end else begin
					v = 1;
					if (n != 1)
						for (longint unsigned i = 0; i < k && ok; i++)
							ok = mul_fits(v, n, v);
				end
			end
			OP_COMB: begin
				if (k > n)
					res.err = ERR_PICK;
				else
					ok = binom_fits(n, k, v);
			end
			OP_MSET: begin
				if (n == 0 && k > 0)
					res.err = ERR_EMPTY;
				else if (n == 0)
					v = 1;
				else
					ok = binom_fits(n + k - 1, k, v);
			end
			default: v = 0;
		endcase
		if (!ok) begin
			v = CNT_MAX;
			res.err = ERR_OVF;
		end
		res.val = v;
		return res;
	endfunction

	function automatic stim_row_t row(input logic [OP_W-1:0] op, input int n, input int k,
			input bit typed = 0, input logic [VALUE_W-1:0] val = '0,
			input logic [ERR_W-1:0] err = ERR_OK);
		stim_row_t r;
		r.op = op;
		r.n = SIZE_W'(n);
		r.k = SIZE_W'(k);
		r.typed = typed;
		r.val = val;
		r.err = err;
		return r;
	endfunction

	task automatic send_item(input stim_row_t r);
		count_res_t e;
		int gap;
		gap = 0;
		if (idling_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 13);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= r.op;
		in_ch.set_size   <= r.n;
		in_ch.pick_count <= r.k;
		do @(posedge clk); while (!in_ch.ready);
		if (r.typed) begin
			e.val = r.val;
			e.err = r.err;
		end else begin
			e = predict_count(r.op, r.n, r.k);
		end
		pending_counts.push_back(e);
		items_sent++;
	endtask

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 9))
			0, 1:    return SIZE_W'($urandom);
			2:       return SIZE_W'($urandom_range(60, 70));
			default: return SIZE_W'($urandom_range(0, 24));
		endcase
	endfunction

	// output side: stall bursts and checking
	always @(posedge clk or negedge arst_n) begin
		count_res_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (pending_counts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: count %0d err %0d",
							out_ch.count_value, out_ch.error_code);
				end else begin
					e = pending_counts.pop_front();
					if (out_ch.count_value !== e.val || out_ch.error_code !== e.err) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp count %0d err %0d, got count %0d err %0d",
								e.val, e.err, out_ch.count_value, out_ch.error_code);
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ch.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				out_stall = $urandom_range(1, 13) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t table_rows[$];
		stim_row_t r;
		int wait_cyc;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		cycles = 0;
		idling_on = 1'b1;
		in_ch.valid      <= 1'b0;
		in_ch.operation  <= '0;
		in_ch.set_size   <= '0;
		in_ch.pick_count <= '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_rows.push_back(row(OP_FACT, 0, 7, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_FACT, 20, 0, 1, 64'd2432902008176640000, ERR_OK));
		table_rows.push_back(row(OP_FACT, 21, 0, 1, CNT_MAX, ERR_OVF));
		table_rows.push_back(row(OP_FACT, 65535, 65535, 1, CNT_MAX, ERR_OVF));
		table_rows.push_back(row(OP_PERM, 3, 4, 1, 0, ERR_PICK));
		table_rows.push_back(row(OP_PERM, 65535, 65535, 1, CNT_MAX, ERR_OVF));
		table_rows.push_back(row(OP_PERM, 5, 0, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_PERM, 10, 3, 1, 720, ERR_OK));
		table_rows.push_back(row(OP_POW, 0, 0, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_POW, 0, 5, 1, 0, ERR_EMPTY));
		table_rows.push_back(row(OP_POW, 1, 65535, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_POW, 2, 63, 1, 64'h8000_0000_0000_0000, ERR_OK));
		table_rows.push_back(row(OP_POW, 2, 64, 1, CNT_MAX, ERR_OVF));
		table_rows.push_back(row(OP_POW, 65535, 0, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_COMB, 3, 5, 1, 0, ERR_PICK));
		table_rows.push_back(row(OP_COMB, 0, 0, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_COMB, 65535, 65535, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_COMB, 65535, 1, 1, 65535, ERR_OK));
		table_rows.push_back(row(OP_COMB, 67, 33));
		table_rows.push_back(row(OP_COMB, 68, 34));
		table_rows.push_back(row(OP_MSET, 0, 0, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_MSET, 0, 1, 1, 0, ERR_EMPTY));
		table_rows.push_back(row(OP_MSET, 1, 65535, 1, 1, ERR_OK));
		table_rows.push_back(row(OP_MSET, 65535, 1, 1, 65535, ERR_OK));
		table_rows.push_back(row(3'd5, 65535, 65535, 1, 0, ERR_OK));
		table_rows.push_back(row(3'd7, 0, 0, 1, 0, ERR_OK));
		foreach (table_rows[i])
			send_item(table_rows[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			// idle stretches alternate with calm ones; the tail runs at full rate
			idling_on = (i < N_RANDOM - CALM_TAIL) && ((i % 60) < 42);
			r.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			r.n = rand_size();
			r.k = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 3)) : rand_size();
			r.typed = 1'b0;
			send_item(r);
		end
		in_ch.valid <= 1'b0;

		wait_cyc = 0;
		while (pending_counts.size() != 0 && wait_cyc < 200000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (50) @(posedge clk);

		$display("sent %0d items over all five counts and unused codes, %0d results checked",
			items_sent, results_seen);
		$display("%0d mismatches, %0d expectations left", mismatches, pending_counts.size());
		if (mismatches == 0 && pending_counts.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== combinatorial_counting_unit.f =====
hdl/ccu_pkg.sv
hdl/ccu_if.sv
hdl/ccu_front.sv
hdl/ccu_queue.sv
hdl/ccu_back.sv
hdl/combinatorial_counting_unit.sv
bench/tb_combinatorial_counting_unit.sv
